FILE: rtl/core/hpt_pkg.sv
package hpt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_REGS      = 8;
   localparam int MAT_IDX_W     = $clog2(NUM_REGS);
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 64;
   localparam int COORD_W       = 32;
   localparam int PROD_W        = 2 * COORD_W;
   // exact row sum: three products plus the offset term, with headroom
   localparam int SW            = PROD_W + 2;
   // quotient bits produced by the divider
   localparam int Q_W           = COORD_W;
   // divider working width: divisor shifted by the full quotient width
   localparam int AW            = SW + Q_W;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SAT   = 2'd1;
   localparam logic [1:0] STATUS_WZERO = 2'd2;

   localparam logic [COORD_W-1:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] S32_MIN = 32'h8000_0000;

   typedef logic [NUM_REGS-1:0][CSR_DATA_W-1:0] mat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] result_x;
      logic signed [COORD_W-1:0] result_y;
      logic signed [COORD_W-1:0] result_z;
      logic [1:0]                status;
   } rsp_type;

   // per lane: result already settled (bypass), its value and saturation flag
   typedef struct packed {
      logic               byp;
      logic               sat;
      logic               neg;
      logic [COORD_W-1:0] val;
   } lane_side_type;

   typedef struct packed {
      lane_side_type [2:0] lane;
      logic                zero_w;
   } div_side_type;

   // coefficient m[row][col]; low half holds the even column
   function automatic logic signed [COORD_W-1:0] coef(mat_type m, int row, int col);
      logic [CSR_DATA_W-1:0] r;
      r = m[MAT_IDX_W'(row * 2 + (col >> 1))];
      return signed'(((col & 1) != 0) ? r[CSR_DATA_W-1:COORD_W] : r[COORD_W-1:0]);
   endfunction

endpackage

FILE: rtl/core/hpt_mac.sv
module hpt_mac #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  hpt_pkg::req_type                  in_req,
   input  hpt_pkg::mat_type                  mat,
   output logic                              out_valid,
   output logic [3:0][hpt_pkg::SW-1:0]       out_sum
);
   import hpt_pkg::*;

   logic signed [COORD_W-1:0] pt [3];
   logic [2:0]                vld_ff, vld_in;
   logic signed [PROD_W-1:0]  prod_ff [4][3];
   logic signed [PROD_W-1:0]  prod_in [4][3];
   logic signed [SW-1:0]      pa_ff [4], pa_in [4];
   logic signed [SW-1:0]      pb_ff [4], pb_in [4];
   logic signed [SW-1:0]      rnd_ff [4], rnd_in [4];

   assign pt[0] = in_req.point_x;
   assign pt[1] = in_req.point_y;
   assign pt[2] = in_req.point_z;

   assign vld_in = {vld_ff[1:0], in_valid};

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = PROD_W'(coef(mat, r, c)) * PROD_W'(pt[c]);
         end
         pa_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]);
         // offset column plus half an LSB for round to nearest, ties up
         pb_in[r] = SW'(prod_ff[r][2]) + (SW'(coef(mat, r, 3)) <<< FRAC_BITS)
                  + (SW'(1) <<< (FRAC_BITS - 1));
         rnd_in[r] = (pa_ff[r] + pb_ff[r]) >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         rnd_ff  <= rnd_in;
      end
   end

   assign out_valid = vld_ff[2];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         out_sum[r] = rnd_ff[r];
      end
   end

endmodule

FILE: rtl/core/hpt_prep.sv
module hpt_prep #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [3:0][hpt_pkg::SW-1:0]      in_sum,
   output logic                             out_valid,
   output logic [2:0][hpt_pkg::AW-1:0]      out_rem,
   output logic [hpt_pkg::SW-1:0]           out_dvs,
   output hpt_pkg::div_side_type            out_side
);
   import hpt_pkg::*;

   logic                 vld_ff;
   logic [2:0][AW-1:0]   rem_ff, rem_in;
   logic [SW-1:0]        dvs_ff, dvs_in;
   div_side_type         side_ff, side_in;

   logic signed [SW-1:0] rw;
   logic signed [SW-1:0] rv;
   logic                 unity;
   logic [AW-1:0]        dshift;
   logic [SW-1:0]        un;
   logic                 neg_v;
   logic                 fits;
   logic                 presat;
   logic                 neg_q;

   always_comb begin
      rw        = signed'(in_sum[3]);
      side_in   = '0;
      side_in.zero_w = (rw == '0);
      unity     = (rw == (SW'(1) <<< FRAC_BITS));
      dvs_in    = rw[SW-1] ? SW'(-rw) : SW'(rw);
      dshift    = AW'(dvs_in) << Q_W;
      rv = '0; un = '0; neg_v = 1'b0; fits = 1'b0; presat = 1'b0; neg_q = 1'b0;
      for (int k = 0; k < 3; k++) begin
         rv     = signed'(in_sum[k]);
         neg_v  = rv[SW-1];
         un     = neg_v ? SW'(-rv) : SW'(rv);
         rem_in[k] = AW'(un) << FRAC_BITS;
         presat = (rem_in[k] >= dshift);
         fits   = (&rv[SW-1:COORD_W-1]) | ~(|rv[SW-1:COORD_W-1]);
         neg_q  = neg_v ^ rw[SW-1];
         side_in.lane[k].neg = neg_q;
         if (side_in.zero_w) begin
            side_in.lane[k].byp = 1'b1;
            side_in.lane[k].val = neg_v ? S32_MIN : S32_MAX;
         end else if (unity) begin
            side_in.lane[k].byp = 1'b1;
            side_in.lane[k].sat = ~fits;
            side_in.lane[k].val = fits ? rv[COORD_W-1:0] : (neg_v ? S32_MIN : S32_MAX);
         end else if (presat) begin
            // quotient needs more than Q_W bits
            side_in.lane[k].byp = 1'b1;
            side_in.lane[k].sat = 1'b1;
            side_in.lane[k].val = neg_q ? S32_MIN : S32_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_rem   = rem_ff;
   assign out_dvs   = dvs_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/core/hpt_divider.sv
module hpt_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [2:0][hpt_pkg::AW-1:0]      in_rem,
   input  logic [hpt_pkg::SW-1:0]           in_dvs,
   input  hpt_pkg::div_side_type            in_side,
   output logic                             out_valid,
   output logic [2:0][hpt_pkg::Q_W-1:0]     out_quo,
   output hpt_pkg::div_side_type            out_side
);
   import hpt_pkg::*;

   // one restoring step per stage, most significant quotient bit first
   logic               vld_ff  [Q_W];
   logic [2:0][AW-1:0] rem_ff  [Q_W];
   logic [2:0][Q_W-1:0] quo_ff [Q_W];
   logic [SW-1:0]      dvs_ff  [Q_W];
   div_side_type       side_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic                src_v;
      logic [2:0][AW-1:0]  src_rem;
      logic [2:0][Q_W-1:0] src_quo;
      logic [SW-1:0]       src_dvs;
      div_side_type        src_side;
      logic [AW-1:0]       sub;
      logic [2:0][AW-1:0]  rem_in;
      logic [2:0][Q_W-1:0] quo_in;

      if (s == 0) begin : g_src
         assign src_v    = in_valid;
         assign src_rem  = in_rem;
         assign src_quo  = '0;
         assign src_dvs  = in_dvs;
         assign src_side = in_side;
      end else begin : g_src
         assign src_v    = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_quo  = quo_ff[s-1];
         assign src_dvs  = dvs_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      always_comb begin
         sub = AW'(src_dvs) << (Q_W - 1 - s);
         for (int k = 0; k < 3; k++) begin
            if (src_rem[k] >= sub) begin
               rem_in[k] = src_rem[k] - sub;
               quo_in[k] = {src_quo[k][Q_W-2:0], 1'b1};
            end else begin
               rem_in[k] = src_rem[k];
               quo_in[k] = {src_quo[k][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            dvs_ff[s]  <= src_dvs;
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quo   = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

FILE: rtl/core/homogeneous_point_transform.sv
// Homogeneous point transform: each request carries a point (x, y, z) in
// signed fixed point with FRAC_BITS fraction bits; the block forms
// (x, y, z, 1), multiplies it by the 4x4 matrix held in the eight csr_
// registers (reset gives identity) and returns x'/w', y'/w', z'/w', or the
// sums themselves when w' rounds to exactly 1.0. Row sums are exact and
// rounded to nearest with ties upward; quotients truncate toward zero and
// saturate to 32 bits, status reporting saturation (1) or a zero w' (2, with
// each result at full scale in the numerator's direction). Fully pipelined:
// one point per cycle sustained while the skid entry stays empty (req_stall low)
// (37 register stages: 3 multiply/add stages, 1 divide set-up stage, 32
// one-bit restoring divide stages - one per quotient bit - and the output
// register; the first stage loads at the accepting edge).
// A two-entry output register/skid pair decouples rsp_stall from the
// pipeline, so req_stall is registered. Matrix writes are taken every cycle
// (csr_ready is always high) and must only happen while the block is idle.
module homogeneous_point_transform #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hpt_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hpt_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hpt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hpt_pkg::*;

   // identity: 1.0 on the diagonal, in the low or high half as the column says
   localparam logic [COORD_W-1:0] ONE = COORD_W'(1 << FRAC_BITS);
   localparam logic [CSR_DATA_W-1:0] ONE_LO = {{COORD_W{1'b0}}, ONE};
   localparam logic [CSR_DATA_W-1:0] ONE_HI = {ONE, {COORD_W{1'b0}}};
   localparam logic [CSR_DATA_W-1:0] ZERO_R = {CSR_DATA_W{1'b0}};
   // registers 7 down to 0
   localparam mat_type MAT_RESET = {ONE_HI, ZERO_R, ONE_LO, ZERO_R,
                                    ZERO_R, ONE_HI, ZERO_R, ONE_LO};

   mat_type mat_ff;

   // pipeline nets
   logic                adv;
   logic                mac_v;
   logic [3:0][SW-1:0]  mac_sum;
   logic                prep_v;
   logic [2:0][AW-1:0]  prep_rem;
   logic [SW-1:0]       prep_dvs;
   div_side_type        prep_side;
   logic                div_v;
   logic [2:0][Q_W-1:0] div_quo;
   div_side_type        div_side;

   // output register and skid
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type skid_ff, skid_in;
   rsp_type fin;
   logic    take;

   // ---- matrix registers ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         mat_ff[csr_index[MAT_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // whole pipeline moves unless the skid entry is occupied
   assign adv       = ~skid_v_ff;
   assign req_stall = skid_v_ff;

   hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .mat       (mat_ff),
      .out_valid (mac_v),
      .out_sum   (mac_sum)
   );

   hpt_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (mac_v),
      .in_sum    (mac_sum),
      .out_valid (prep_v),
      .out_rem   (prep_rem),
      .out_dvs   (prep_dvs),
      .out_side  (prep_side)
   );

   hpt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (prep_v),
      .in_rem    (prep_rem),
      .in_dvs    (prep_dvs),
      .in_side   (prep_side),
      .out_valid (div_v),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // ---- final range check, sign and status ----
   always_comb begin
      logic [COORD_W-1:0] val [3];
      logic [2:0]         sat;
      logic               over;
      logic [Q_W-1:0]     q;
      over = 1'b0;
      q    = '0;
      for (int k = 0; k < 3; k++) begin
         q = div_quo[k];
         if (div_side.lane[k].byp) begin
            val[k] = div_side.lane[k].val;
            sat[k] = div_side.lane[k].sat;
         end else begin
            // negative results may reach -2^31, positive ones 2^31 - 1
            over = div_side.lane[k].neg ? (q[Q_W-1] & (|q[Q_W-2:0])) : q[Q_W-1];
            if (over) begin
               val[k] = div_side.lane[k].neg ? S32_MIN : S32_MAX;
            end else begin
               val[k] = div_side.lane[k].neg ? COORD_W'(-q) : COORD_W'(q);
            end
            sat[k] = over;
         end
      end
      fin.result_x = signed'(val[0]);
      fin.result_y = signed'(val[1]);
      fin.result_z = signed'(val[2]);
      if (div_side.zero_w) begin
         fin.status = STATUS_WZERO;
      end else if (|sat) begin
         fin.status = STATUS_SAT;
      end else begin
         fin.status = STATUS_OK;
      end
   end

   // ---- output register with skid ----
   assign take = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      skid_v_in    = skid_v_ff;
      skid_in      = skid_ff;
      if (!rsp_valid_ff || take) begin
         if (skid_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = skid_ff;
            skid_v_in    = 1'b0;
         end else begin
            rsp_valid_in = div_v & adv;
            rsp_in       = fin;
         end
      end else if (div_v && adv) begin
         skid_v_in = 1'b1;
         skid_in   = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_v_ff    <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   // skid only fills behind a held response
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid entry occupied without a pending response");

   // a full skid with a stalled response stays full
   a_skid_kept : assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_stall) |=> skid_v_ff)
      else $error("skid entry dropped while response stalled");

   // zero w gives a full-scale x result
   a_wzero_full_scale : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_WZERO)) |->
         ((rsp_ff.result_x == S32_MAX) || (rsp_ff.result_x == S32_MIN)))
      else $error("zero w response not saturated");

endmodule
